@@ src/nonpreemptive_sjf_scheduler_defines.svh @@
// Assertion macros for the shortest-job-first scheduler.
// Included by the scheduler top level, which carries the concurrent assertions; no other dependencies.
`ifndef NONPREEMPTIVE_SJF_SCHEDULER_DEFINES_SVH
`define NONPREEMPTIVE_SJF_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
`define SJF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SJF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SJF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SJF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ src/sjf_pkg.sv @@
// Shared types and constants of the shortest-job-first scheduler.
// Used by the process cells, the pick unit and the top level; no dependencies.
`timescale 1ns / 1ps

package sjf_pkg;

    localparam int FIELD_W = 16;
    localparam int TIME_W  = 21;
    localparam int SUM_W   = 25;

    typedef struct packed {
        logic [FIELD_W-1:0] process_id;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
        logic               last_process;
    } sjf_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] pid_out;
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  end_time;
        logic [TIME_W-1:0]  waiting_time;
        logic [SUM_W-1:0]   total_waiting;
        logic               last_result;
    } sjf_out_t;

    typedef struct packed {
        logic               valid;
        logic               done;
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
    } sjf_entry_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } sjf_cell_ctrl_t;

    typedef struct packed {
        logic en;
        logic first;
        logic retire;
    } sjf_pick_ctrl_t;

    typedef struct packed {
        logic               found;
        logic               arrived;
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
    } sjf_pick_t;

    typedef enum logic [1:0] {
        SJF_LOAD,
        SJF_SCAN,
        SJF_EMIT
    } sjf_state_t;

endpackage

@@ src/sjf_cell.sv @@
// One cell of the process ring: holds one process entry and its load-order tag.
// Depends on sjf_pkg for the entry and control types.
`timescale 1ns / 1ps

module sjf_cell import sjf_pkg::*; #(
    parameter int IDX_W = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sjf_cell_ctrl_t   ctrl,
    input  sjf_entry_t       entry_in,
    input  logic [IDX_W-1:0] tag_in,
    output sjf_entry_t       entry_out,
    output logic [IDX_W-1:0] tag_out
);

    logic               valid_reg;
    logic               done_reg;
    logic [FIELD_W-1:0] id_reg;
    logic [FIELD_W-1:0] arrival_reg;
    logic [FIELD_W-1:0] burst_reg;
    logic [IDX_W-1:0]   tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= entry_in.valid;
            done_reg  <= entry_in.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            id_reg      <= entry_in.id;
            arrival_reg <= entry_in.arrival;
            burst_reg   <= entry_in.burst;
            tag_reg     <= tag_in;
        end
    end

    assign entry_out.valid   = valid_reg;
    assign entry_out.done    = done_reg;
    assign entry_out.id      = id_reg;
    assign entry_out.arrival = arrival_reg;
    assign entry_out.burst   = burst_reg;
    assign tag_out           = tag_reg;

endmodule

@@ src/sjf_pick.sv @@
// Pick unit: while enabled, examines the head entry of the ring once per cycle and keeps
// the best arrived candidate and the earliest-arriving candidate. Depends on sjf_pkg.
`timescale 1ns / 1ps

module sjf_pick import sjf_pkg::*; #(
    parameter int IDX_W = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sjf_pick_ctrl_t    ctrl,
    input  sjf_entry_t        head,
    input  logic [IDX_W-1:0]  head_tag,
    input  logic [TIME_W-1:0] cur_time,
    output sjf_pick_t         sel,
    output logic [IDX_W-1:0]  sel_tag
);

    logic               a_found_reg, a_found_next;
    logic [FIELD_W-1:0] a_id_reg, a_arr_reg, a_burst_reg;
    logic [IDX_W-1:0]   a_tag_reg;
    logic               b_found_reg, b_found_next;
    logic [FIELD_W-1:0] b_id_reg, b_arr_reg, b_burst_reg;
    logic [IDX_W-1:0]   b_tag_reg;

    logic               eligible;
    logic               arrived;
    logic               a_have;
    logic               b_have;
    logic               a_take;
    logic               b_take;
    logic [TIME_W-1:0]  head_arr_ext;

    assign head_arr_ext = {{(TIME_W-FIELD_W){1'b0}}, head.arrival};
    assign eligible     = head.valid && !head.done && !ctrl.retire;
    assign arrived      = eligible && (head_arr_ext <= cur_time);
    assign a_have       = a_found_reg && !ctrl.first;
    assign b_have       = b_found_reg && !ctrl.first;

    always_comb begin
        a_take = arrived && (!a_have || (head.burst < a_burst_reg));
        b_take = eligible && (!b_have || (head.arrival < b_arr_reg) ||
                 ((head.arrival == b_arr_reg) && (head.burst < b_burst_reg)));
        a_found_next = a_have || a_take;
        b_found_next = b_have || b_take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_found_reg <= 1'b0;
            b_found_reg <= 1'b0;
        end else if (ctrl.en) begin
            a_found_reg <= a_found_next;
            b_found_reg <= b_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en && a_take) begin
            a_id_reg    <= head.id;
            a_arr_reg   <= head.arrival;
            a_burst_reg <= head.burst;
            a_tag_reg   <= head_tag;
        end
        if (ctrl.en && b_take) begin
            b_id_reg    <= head.id;
            b_arr_reg   <= head.arrival;
            b_burst_reg <= head.burst;
            b_tag_reg   <= head_tag;
        end
    end

    always_comb begin
        sel.found   = a_found_reg || b_found_reg;
        sel.arrived = a_found_reg;
        if (a_found_reg) begin
            sel.id      = a_id_reg;
            sel.arrival = a_arr_reg;
            sel.burst   = a_burst_reg;
            sel_tag     = a_tag_reg;
        end else begin
            sel.id      = b_id_reg;
            sel.arrival = b_arr_reg;
            sel.burst   = b_burst_reg;
            sel_tag     = b_tag_reg;
        end
    end

endmodule

@@ src/nonpreemptive_sjf_scheduler.sv @@
// Non-preemptive shortest-job-first scheduler over a ring of MAX_PROCS process cells.
// After the flagged last process, each result is found in one full rotation of the cell
// ring past the pick unit and is then formed into the output register once it is free.
// Reset is synchronous and active low; it empties the ring and returns to loading.
// Depends on sjf_pkg, sjf_cell, sjf_pick and the assertion macro header.
`timescale 1ns / 1ps
`include "nonpreemptive_sjf_scheduler_defines.svh"

module nonpreemptive_sjf_scheduler import sjf_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sjf_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sjf_out_t m_data
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_PROCS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_PROCS);

    sjf_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [TIME_W-1:0]  cur_time_reg, cur_time_next;
    logic [SUM_W-1:0]   wsum_reg, wsum_next;
    logic               have_prev_reg, have_prev_next;
    logic [IDX_W-1:0]   prev_tag_reg, prev_tag_next;
    logic               m_valid_reg, m_valid_next;
    sjf_out_t           m_data_reg, m_data_next;

    sjf_entry_t         ent [MAX_PROCS];
    logic [IDX_W-1:0]   tag [MAX_PROCS];
    sjf_entry_t         tail_entry;
    logic [IDX_W-1:0]   tail_tag;
    sjf_cell_ctrl_t     cell_ctrl;
    sjf_pick_ctrl_t     pick_ctrl;
    sjf_pick_t          sel;
    logic [IDX_W-1:0]   sel_tag;

    logic               s_fire;
    logic               store;
    logic               out_free;
    logic               emit_fire;
    logic               last_pick;
    logic               retire;
    logic [TIME_W-1:0]  sel_arr_ext;
    logic [TIME_W-1:0]  start_t;
    logic [TIME_W-1:0]  end_t;
    logic [TIME_W-1:0]  wait_t;
    logic [SUM_W-1:0]   sum_t;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PROCS; gi++) begin : g_cell
            if (gi == MAX_PROCS - 1) begin : g_tail
                sjf_cell #(.IDX_W(IDX_W)) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .ctrl      (cell_ctrl),
                    .entry_in  (tail_entry),
                    .tag_in    (tail_tag),
                    .entry_out (ent[gi]),
                    .tag_out   (tag[gi])
                );
            end else begin : g_body
                sjf_cell #(.IDX_W(IDX_W)) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .ctrl      (cell_ctrl),
                    .entry_in  (ent[gi+1]),
                    .tag_in    (tag[gi+1]),
                    .entry_out (ent[gi]),
                    .tag_out   (tag[gi])
                );
            end
        end
    endgenerate

    sjf_pick #(.IDX_W(IDX_W)) u_pick (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (pick_ctrl),
        .head     (ent[0]),
        .head_tag (tag[0]),
        .cur_time (cur_time_reg),
        .sel      (sel),
        .sel_tag  (sel_tag)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign last_pick = (k_reg == (count_reg - CNT_W'(1)));
    assign retire    = have_prev_reg && (tag[0] == prev_tag_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SJF_LOAD: begin
                if (s_valid && s_data.last_process) begin
                    state_next = SJF_SCAN;
                end
            end
            SJF_SCAN: begin
                if (scan_cnt_reg == LAST_SLOT) begin
                    state_next = SJF_EMIT;
                end
            end
            SJF_EMIT: begin
                if (out_free) begin
                    state_next = last_pick ? SJF_LOAD : SJF_SCAN;
                end
            end
            default: begin
                state_next = SJF_LOAD;
            end
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        emit_fire       = 1'b0;
        pick_ctrl.en    = 1'b0;
        pick_ctrl.first = (scan_cnt_reg == '0);
        pick_ctrl.retire = retire;
        unique case (state_reg)
            SJF_LOAD: begin
                s_ready = 1'b1;
            end
            SJF_SCAN: begin
                pick_ctrl.en = 1'b1;
            end
            SJF_EMIT: begin
                emit_fire = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign s_fire = s_valid && s_ready;
    assign store  = s_fire && (count_reg != FULL_CNT);

    always_comb begin
        cell_ctrl.shift = store || (state_reg == SJF_SCAN);
        cell_ctrl.clear = emit_fire && last_pick;
        if (state_reg == SJF_LOAD) begin
            tail_entry.valid   = 1'b1;
            tail_entry.done    = 1'b0;
            tail_entry.id      = s_data.process_id;
            tail_entry.arrival = s_data.arrival;
            tail_entry.burst   = s_data.burst;
            tail_tag           = count_reg[IDX_W-1:0];
        end else begin
            tail_entry      = ent[0];
            tail_entry.done = ent[0].done || retire;
            tail_tag        = tag[0];
        end
    end

    assign sel_arr_ext = {{(TIME_W-FIELD_W){1'b0}}, sel.arrival};
    assign start_t     = sel.arrived ? cur_time_reg : sel_arr_ext;
    assign end_t       = start_t + {{(TIME_W-FIELD_W){1'b0}}, sel.burst};
    assign wait_t      = start_t - sel_arr_ext;
    assign sum_t       = wsum_reg + {{(SUM_W-TIME_W){1'b0}}, wait_t};

    always_comb begin
        count_next     = count_reg;
        k_next         = k_reg;
        scan_cnt_next  = scan_cnt_reg;
        cur_time_next  = cur_time_reg;
        wsum_next      = wsum_reg;
        have_prev_next = have_prev_reg;
        prev_tag_next  = prev_tag_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        if (store) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (state_reg == SJF_SCAN) begin
            scan_cnt_next = (scan_cnt_reg == LAST_SLOT) ? '0 : scan_cnt_reg + IDX_W'(1);
        end
        if (emit_fire) begin
            m_valid_next              = 1'b1;
            m_data_next.pid_out       = sel.id;
            m_data_next.start_time    = start_t;
            m_data_next.end_time      = end_t;
            m_data_next.waiting_time  = wait_t;
            m_data_next.total_waiting = sum_t;
            m_data_next.last_result   = last_pick;
            prev_tag_next             = sel_tag;
            if (last_pick) begin
                count_next     = '0;
                k_next         = '0;
                cur_time_next  = '0;
                wsum_next      = '0;
                have_prev_next = 1'b0;
            end else begin
                k_next         = k_reg + CNT_W'(1);
                cur_time_next  = end_t;
                wsum_next      = sum_t;
                have_prev_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SJF_LOAD;
            count_reg     <= '0;
            k_reg         <= '0;
            scan_cnt_reg  <= '0;
            cur_time_reg  <= '0;
            wsum_reg      <= '0;
            have_prev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            scan_cnt_reg  <= scan_cnt_next;
            cur_time_reg  <= cur_time_next;
            wsum_reg      <= wsum_next;
            have_prev_reg <= have_prev_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_tag_reg <= prev_tag_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SJF_ASSERT_IMP(a_emit_has_pick, aclk, aresetn, state_reg == SJF_EMIT, sel.found, "No candidate found at the end of a scan.")
    `SJF_ASSERT_IMP(a_jump_forward, aclk, aresetn, state_reg == SJF_EMIT && sel.found && !sel.arrived, sel_arr_ext > cur_time_reg, "Idle jump would move the clock backwards.")
    `SJF_ASSERT_NXT(a_set_cleared, aclk, aresetn, emit_fire && last_pick, count_reg == '0 && state_reg == SJF_LOAD && !have_prev_reg, "Set not cleared after its final transfer.")
    `SJF_ASSERT_IMP(a_pick_in_range, aclk, aresetn, state_reg != SJF_LOAD, count_reg != '0 && k_reg < count_reg, "Pick counter outside the loaded set.")

endmodule

@@ verif/sjf_schedule_checker.sv @@
// Checker for the shortest-job-first scheduler: watches both channels, keeps its own
// process table, predicts the run order of each set and compares every result transfer.
// Depends on sjf_pkg for the payload types and widths.
`timescale 1ns / 1ps

module sjf_schedule_checker import sjf_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  sjf_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  sjf_out_t m_data,
    output int       mismatches,
    output int       pending
);

    logic [FIELD_W-1:0] tab_id      [MAX_PROCS];
    logic [FIELD_W-1:0] tab_arrival [MAX_PROCS];
    logic [FIELD_W-1:0] tab_burst   [MAX_PROCS];
    int                 n_loaded;
    sjf_out_t           expected_runs [$];

    initial begin
        mismatches = 0;
        pending    = 0;
        n_loaded   = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: schedule check failed: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
        end
    endtask

    task automatic schedule_set();
        logic [MAX_PROCS-1:0] finished;
        logic [TIME_W-1:0]    clock_now;
        logic [TIME_W-1:0]    start_at;
        logic [TIME_W-1:0]    stop_at;
        logic [TIME_W-1:0]    wait_len;
        logic [SUM_W-1:0]     wait_total;
        logic [FIELD_W-1:0]   earliest;
        bit                   any_left;
        int                   best;
        sjf_out_t             run;
        finished   = '0;
        clock_now  = '0;
        wait_total = '0;
        for (int k = 0; k < n_loaded; k++) begin
            any_left = 0;
            earliest = '0;
            for (int i = 0; i < n_loaded; i++) begin
                if (!finished[i] && (!any_left || tab_arrival[i] < earliest)) begin
                    earliest = tab_arrival[i];
                    any_left = 1;
                end
            end
            if (any_left && TIME_W'(earliest) > clock_now) begin
                clock_now = TIME_W'(earliest);
            end
            best = 0;
            any_left = 0;
            for (int i = 0; i < n_loaded; i++) begin
                if (!finished[i] && TIME_W'(tab_arrival[i]) <= clock_now &&
                    (!any_left || tab_burst[i] < tab_burst[best])) begin
                    best = i;
                    any_left = 1;
                end
            end
            start_at      = clock_now;
            stop_at       = start_at + TIME_W'(tab_burst[best]);
            wait_len      = start_at - TIME_W'(tab_arrival[best]);
            finished[best] = 1'b1;
            clock_now     = stop_at;
            wait_total    = wait_total + SUM_W'(wait_len);
            run.pid_out       = tab_id[best];
            run.start_time    = start_at;
            run.end_time      = stop_at;
            run.waiting_time  = wait_len;
            run.total_waiting = wait_total;
            run.last_result   = (k + 1 == n_loaded);
            expected_runs.push_back(run);
        end
        n_loaded = 0;
    endtask

    task automatic accept_process(input sjf_in_t item);
        if (n_loaded < MAX_PROCS) begin
            tab_id[n_loaded]      = item.process_id;
            tab_arrival[n_loaded] = item.arrival;
            tab_burst[n_loaded]   = item.burst;
            n_loaded++;
        end
        if (item.last_process) begin
            schedule_set();
        end
    endtask

    task automatic compare_run(input sjf_out_t got);
        sjf_out_t want;
        if (expected_runs.size() == 0) begin
            report_mismatch($sformatf("result transfer for id %0d with none expected",
                                      got.pid_out));
        end else begin
            want = expected_runs.pop_front();
            check_field("pid_out", want.pid_out, got.pid_out);
            check_field("start_time", want.start_time, got.start_time);
            check_field("end_time", want.end_time, got.end_time);
            check_field("waiting_time", want.waiting_time, got.waiting_time);
            check_field("total_waiting", want.total_waiting, got.total_waiting);
            check_field("last_result", want.last_result, got.last_result);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            n_loaded = 0;
            expected_runs.delete();
        end else begin
            if (m_valid && m_ready) begin
                compare_run(m_data);
            end
            if (s_valid && s_ready) begin
                accept_process(s_data);
            end
        end
        pending <= expected_runs.size();
    end

endmodule

@@ verif/tb_nonpreemptive_sjf_scheduler.sv @@
// Testbench top for the shortest-job-first scheduler: drives process sets with random
// gaps and result stalls, and gives the verdict from the checker's mismatch and pending counts.
// Depends on sjf_pkg, the scheduler RTL and sjf_schedule_checker.
`timescale 1ns / 1ps

module tb_nonpreemptive_sjf_scheduler;
    import sjf_pkg::*;

    localparam int MAX_PROCS    = 16;
    localparam int TARGET_ITEMS = 310;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 3 * (MAX_PROCS + 1);

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sjf_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sjf_out_t m_data;
    int       mismatches;
    int       pending;
    int       cycles = 0;
    int       stored_items = 0;
    bit       quiet = 1'b0;

    always #5 aclk = ~aclk;

    nonpreemptive_sjf_scheduler #(
        .MAX_PROCS(MAX_PROCS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sjf_schedule_checker #(
        .MAX_PROCS(MAX_PROCS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[nonpreemptive_sjf_scheduler] ERROR");
            $finish;
        end
    end

    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = quiet ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_process(input logic [FIELD_W-1:0] id, input logic [FIELD_W-1:0] arr,
                                input logic [FIELD_W-1:0] len, input logic last);
        sjf_in_t item;
        int      gap;
        item.process_id   = id;
        item.arrival      = arr;
        item.burst        = len;
        item.last_process = last;
        gap = quiet ? 0 : $urandom_range(0, 17);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        int set_size;
        int arr_mode;
        int len_mode;
        logic [FIELD_W-1:0] arr;
        logic [FIELD_W-1:0] len;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        send_process(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_process(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_process(16'd1, 16'd0, 16'd5, 1'b0);
        send_process(16'd2, 16'd0, 16'd5, 1'b0);
        send_process(16'd3, 16'd100, 16'd1, 1'b0);
        send_process(16'd4, 16'd3, 16'd5, 1'b1);
        for (int j = 0; j <= MAX_PROCS; j++) begin
            send_process(16'($urandom), 16'hFFFF, 16'hFFFF, j == MAX_PROCS);
        end
        stored_items = 6 + MAX_PROCS;
        hold_until_drained();

        while (stored_items < TARGET_ITEMS) begin
            case ($urandom_range(0, 19))
                0:            set_size = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
                1, 2, 3:      set_size = $urandom_range(9, MAX_PROCS);
                default:      set_size = $urandom_range(1, 8);
            endcase
            quiet    = ($urandom_range(0, 3) == 0);
            arr_mode = $urandom_range(0, 3);
            len_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0) begin
                hold_until_drained();
            end
            for (int j = 0; j < set_size; j++) begin
                case (arr_mode)
                    0:       arr = '0;
                    1:       arr = 16'($urandom_range(0, 31));
                    2:       arr = 16'($urandom_range(0, 400));
                    default: arr = 16'($urandom);
                endcase
                case (len_mode)
                    0:       len = 16'($urandom_range(0, 3));
                    1:       len = 16'($urandom_range(0, 40));
                    default: len = 16'($urandom);
                endcase
                send_process(16'($urandom), arr, len, j == set_size - 1);
                if (j < MAX_PROCS) begin
                    stored_items++;
                end
            end
        end

        quiet = 1'b0;
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("[nonpreemptive_sjf_scheduler] OK");
        end else begin
            $display("[nonpreemptive_sjf_scheduler] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/sjf_pkg.sv
src/sjf_cell.sv
src/sjf_pick.sv
src/nonpreemptive_sjf_scheduler.sv
verif/sjf_schedule_checker.sv
verif/tb_nonpreemptive_sjf_scheduler.sv
